### design/ngc_pkg.sv
package ngc_pkg;

  localparam int NUM_WORDS = 5;
  localparam int WORD_W    = 16;
  localparam int CNT_W     = 32;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FIN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic ADDR_ORDER = 1'b0;
  localparam logic ADDR_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    K_NOP,
    K_ADD,
    K_FIN,
    K_READ
  } kind_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] word_0;
    logic [WORD_W-1:0] word_1;
    logic [WORD_W-1:0] word_2;
    logic [WORD_W-1:0] word_3;
    logic [WORD_W-1:0] word_4;
    logic [CNT_W-1:0]  ngram_count;
    logic [1:0]        read_level;
    logic [5:0]        read_bin;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] bin_value;
    logic [CNT_W-1:0] level_total;
  } out_t;

  typedef struct packed {
    kind_e                           kind;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    logic [CNT_W-1:0]                cnt;
    logic [1:0]                      lvl;
    logic [5:0]                      bin;
  } req_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

### design/ngram_count_of_counts_unit.sv
// Count-of-counts statistics over an ascending n-gram stream. Requests enter a
// two-deep queue, then an execute stage that finds the novelty position and
// updates prefix sums and level totals, then a write-back stage that bumps one
// histogram bin per level, each level having its own 32-bit bank with a read
// port and a write port, and then the result register. The bank
// read-modify-write spans the two stages with a bypass, so one request is taken
// per cycle sustained while the output is not stalled. Every request returns
// one result, held in the write-back register and then the result register.
// Bin counters reset via per-entry valid bits, so no clearing pass is needed.
module ngram_count_of_counts_unit import ngc_pkg::*; #(
  parameter int MAX_ORDER = 5,
  parameter int MAX_BIN   = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ORD_W = $clog2(MAX_ORDER + 1);

  logic [2:0]       order_q;
  logic [5:0]       limit_q;
  logic [ORD_W-1:0] n_eff;
  logic [5:0]       lim_eff;
  logic             active;
  req_t             req;
  logic             req_valid, req_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 3'd3;
      limit_q <= 6'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        ADDR_ORDER: order_q <= pwdata[2:0];
        ADDR_LIMIT: limit_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ADDR_ORDER: prdata = {29'd0, order_q};
      ADDR_LIMIT: prdata = {26'd0, limit_q};
      default:    prdata = '0;
    endcase
  end

  assign n_eff   = (int'(order_q) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_q);
  assign lim_eff = (int'(limit_q) > MAX_BIN) ? 6'(MAX_BIN) : limit_q;
  assign active  = (limit_q != 6'd0) && (n_eff >= ORD_W'(2));

  ngc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .active_i    (active),
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop)
  );

  ngc_back #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_BIN   (MAX_BIN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_valid_i (req_valid),
    .req_pop_o   (req_pop),
    .order_i     (n_eff),
    .limit_i     (lim_eff),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_pop |-> req_valid) else $error("pop from empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> req_valid) else $error("queue full yet empty");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_pop && !in_valid_i) |=> !in_stall_o) else $error("pop left queue full");

endmodule

### design/ngc_front.sv
module ngc_front import ngc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  input  logic active_i,
  output req_t req_o,
  output logic req_valid_o,
  input  logic req_pop_i
);

  req_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  req_t       req_d;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = ent_q[rptr_q];
  assign push        = in_valid_i && !in_stall_o;

  always_comb begin
    req_d.words = {in_data_i.word_4, in_data_i.word_3, in_data_i.word_2,
                   in_data_i.word_1, in_data_i.word_0};
    req_d.cnt   = in_data_i.ngram_count;
    req_d.lvl   = in_data_i.read_level;
    req_d.bin   = in_data_i.read_bin;
    case (in_data_i.command)
      CMD_ADD:  req_d.kind = active_i ? K_ADD : K_NOP;
      CMD_FIN:  req_d.kind = active_i ? K_FIN : K_NOP;
      CMD_READ: req_d.kind = K_READ;
      default:  req_d.kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= req_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (req_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(req_pop_i);
    end
  end

endmodule

### design/ngc_back.sv
module ngc_back import ngc_pkg::*; #(
  parameter int MAX_ORDER = 5,
  parameter int MAX_BIN   = 63,
  localparam int ORD_W    = $clog2(MAX_ORDER + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic             req_valid_i,
  output logic             req_pop_o,
  input  logic [ORD_W-1:0] order_i,
  input  logic [5:0]       limit_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  localparam int NUM_LEVELS = MAX_ORDER - 1;
  localparam int NUM_RD     = (NUM_LEVELS < 4) ? NUM_LEVELS : 4;
  localparam int BINS_TOP   = (MAX_BIN < 63) ? MAX_BIN : 63;
  localparam int NUM_BINS   = BINS_TOP + 1;
  localparam int BIN_W      = $clog2(NUM_BINS);

  logic [WORD_W-1:0] prev_q [MAX_ORDER];
  logic [CNT_W-1:0]  pfx_q  [NUM_LEVELS];
  logic [CNT_W-1:0]  pfx_d  [NUM_LEVELS];
  logic [CNT_W-1:0]  tot_q  [NUM_RD];
  logic [CNT_W-1:0]  tot_d  [NUM_RD];
  logic              first_q;
  logic [ORD_W-1:0]  nov_q;
  logic [CNT_W-1:0]  lcnt_q;

  logic [WORD_W-1:0] w     [MAX_ORDER];
  logic [ORD_W-1:0]  pos_a;
  logic              close [NUM_LEVELS];
  logic [CNT_W-1:0]  ccnt  [NUM_LEVELS];
  logic [NUM_RD-1:0] bump;
  logic [BIN_W-1:0]  rd_addr [NUM_RD];
  logic [NUM_RD-1:0] rd_en;
  logic [CNT_W-1:0]  tot_rd;
  logic              rd_ok;

  logic              e_fire, w_fire;
  logic              w_v_q, w_rd_q, w_ok_q;
  logic [1:0]        w_lvl_q;
  logic [CNT_W-1:0]  w_tot_q;
  logic [NUM_RD-1:0] w_bump_q;
  logic [CNT_W-1:0]  cur [NUM_RD];
  logic [CNT_W-1:0]  cur_sel;
  logic              out_v_q;
  out_t              out_q;

  assign w_fire    = w_v_q && (!out_v_q || !out_stall_i);
  assign e_fire    = req_valid_i && (!w_v_q || w_fire);
  assign req_pop_o = e_fire;

  // novelty position, prefix closes and restarts
  always_comb begin
    logic             found;
    logic             upd, do_close, is_add, restart, extend;
    logic [ORD_W-1:0] pos;
    logic [CNT_W-1:0] ucnt;
    is_add = (req_i.kind == K_ADD);
    found  = 1'b0;
    pos_a  = order_i;
    for (int i = 0; i < MAX_ORDER; i++) begin
      w[i] = (i < NUM_WORDS) ? req_i.words[i] : '0;
    end
    for (int i = 0; i < MAX_ORDER; i++) begin
      if (!found && (i < int'(order_i)) && (w[i] > prev_q[i])) begin
        found = 1'b1;
        pos_a = ORD_W'(i);
      end
    end
    upd      = is_add || ((req_i.kind == K_FIN) && !first_q);
    pos      = is_add ? pos_a : ((nov_q > order_i) ? order_i : nov_q);
    ucnt     = is_add ? req_i.cnt : lcnt_q;
    do_close = is_add ? !first_q : 1'b1;
    for (int j = 0; j < NUM_LEVELS; j++) begin
      restart  = upd && (j + 1 >= int'(pos)) && (j + 3 <= int'(order_i));
      extend   = upd && (j + 2 <= int'(pos));
      close[j] = restart && do_close;
      ccnt[j]  = pfx_q[j];
      if (is_add && (j == int'(order_i) - 2)) begin
        close[j] = 1'b1;
        ccnt[j]  = req_i.cnt;
      end
      pfx_d[j] = restart ? ucnt : (extend ? sat_add(pfx_q[j], ucnt) : pfx_q[j]);
    end
  end

  always_comb begin
    tot_rd = '0;
    rd_ok  = (req_i.kind == K_READ) && (int'(req_i.lvl) < NUM_RD) &&
             (int'(req_i.bin) <= MAX_BIN);
    for (int l = 0; l < NUM_RD; l++) begin
      bump[l]    = close[l] && (ccnt[l] <= {26'd0, limit_i});
      tot_d[l]   = close[l] ? sat_add(tot_q[l], 32'd1) : tot_q[l];
      rd_addr[l] = (req_i.kind == K_READ) ? req_i.bin[BIN_W-1:0]
                                          : ccnt[l][BIN_W-1:0];
      rd_en[l]   = bump[l] || ((req_i.kind == K_READ) && (int'(req_i.lvl) == l));
      if (int'(req_i.lvl) == l) tot_rd = tot_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) prev_q[i] <= '0;
      for (int j = 0; j < NUM_LEVELS; j++) pfx_q[j] <= '0;
      for (int l = 0; l < NUM_RD; l++) tot_q[l] <= '0;
      first_q <= 1'b1;
      nov_q   <= ORD_W'(3);
      lcnt_q  <= '0;
    end else if (e_fire) begin
      for (int j = 0; j < NUM_LEVELS; j++) pfx_q[j] <= pfx_d[j];
      for (int l = 0; l < NUM_RD; l++) tot_q[l] <= tot_d[l];
      if (req_i.kind == K_ADD) begin
        for (int i = 0; i < MAX_ORDER; i++) begin
          if (i < int'(order_i)) prev_q[i] <= w[i];
        end
        first_q <= 1'b0;
        nov_q   <= pos_a;
        lcnt_q  <= req_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (e_fire) w_v_q <= 1'b1;
      else if (w_fire) w_v_q <= 1'b0;
      if (w_fire) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_fire) begin
      w_rd_q   <= (req_i.kind == K_READ);
      w_ok_q   <= rd_ok;
      w_lvl_q  <= req_i.lvl;
      w_tot_q  <= (req_i.kind == K_READ) ? tot_rd : '0;
      w_bump_q <= bump;
    end
    if (w_fire) begin
      out_q.bin_value   <= (w_rd_q && w_ok_q) ? cur_sel : '0;
      out_q.level_total <= w_tot_q;
    end
  end

  // one histogram bank per level: read in E, increment and write back in W
  for (genvar gl = 0; gl < NUM_RD; gl++) begin : g_bank
    logic [CNT_W-1:0]    mem_q [NUM_BINS];
    logic [NUM_BINS-1:0] vld_q;
    logic [CNT_W-1:0]    rdat_q;
    logic                rvld_q;
    logic [BIN_W-1:0]    raddr_q;
    logic                lw_en_q;
    logic [BIN_W-1:0]    lw_addr_q;
    logic [CNT_W-1:0]    lw_data_q;
    logic                wr;

    assign wr = w_fire && w_bump_q[gl];
    // last write bypasses the read that shared its edge
    assign cur[gl] = (lw_en_q && (lw_addr_q == raddr_q)) ? lw_data_q
                   : (rvld_q ? rdat_q : '0);

    always_ff @(posedge clk_i) begin
      if (e_fire && rd_en[gl]) begin
        rdat_q  <= mem_q[rd_addr[gl]];
        rvld_q  <= vld_q[rd_addr[gl]];
        raddr_q <= rd_addr[gl];
      end
      if (wr) begin
        mem_q[raddr_q] <= sat_add(cur[gl], 32'd1);
        lw_addr_q      <= raddr_q;
        lw_data_q      <= sat_add(cur[gl], 32'd1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q   <= '0;
        lw_en_q <= 1'b0;
      end else if (wr) begin
        vld_q[raddr_q] <= 1'b1;
        lw_en_q        <= 1'b1;
      end
    end
  end

  always_comb begin
    cur_sel = '0;
    for (int l = 0; l < NUM_RD; l++) begin
      if (int'(w_lvl_q) == l) cur_sel = cur[l];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
